[sv/assert_macros.svh]
// Assertion helpers used by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SMM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Expression must never be true outside reset.
`define SMM_ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg) \
	`SMM_ASSERT(lbl, clk_s, rstn_s, !(expr), msg)

`endif

[sv/smm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 512;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int LIMIT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_BITS   = 32;
	localparam int CNT_CFG_W   = 10;
	localparam int WORD_W      = 2 * ADDR_BITS;

	// Request codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [8:0]  entry_index;
		logic [31:0] entry_net;
		logic [5:0]  prefix_len;
		logic [31:0] lookup_addr;
	} smm_req_t;

	typedef struct packed {
		logic is_lookup;
		logic in_list;
	} smm_res_t;

	// Mask from a prefix length; zero gives no bits, 32 and above give all bits.
	function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [5:0] plen);
		logic [ADDR_BITS-1:0] m;
		if (plen == 6'd0) begin
			m = '0;
		end else if (plen >= 6'(ADDR_BITS)) begin
			m = '1;
		end else begin
			m = {ADDR_BITS{1'b1}} << (6'(ADDR_BITS) - plen);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

[sv/smm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/subnet_membership_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// IPv4 prefix-list matcher.
// Input: an item is taken at a clock edge with start high and busy low.
//   A load item writes network and prefix mask into one table slot; a lookup
//   item checks lookup_addr against slots 0 .. N-1, N as defined below.
// Output: one result per item, shown for one cycle with done high; the
//   receiver cannot hold it off, so no stall exists on that side.
// Config: cfg_we/cfg_wdata write entry_count; write it only while idle.
// Flow:
//   load: result in the cycle after accept, busy stays low, one item a cycle.
//   lookup: the table RAM is scanned one slot per cycle through its single
//   read port, stopping at the first hit or after slot N-1, N being
//   entry_count capped at the table depth. If N is zero the lookup is
//   answered as a miss without a scan. busy is high during the scan, so
//   no new item is taken until it ends.
// Reset: entry_count clears to zero and the block goes idle. Table contents
//   are not cleared; a slot must be loaded before a lookup covers it.

module subnet_membership_matcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire smm_pkg::smm_req_t              req,
	output logic                                done,
	output smm_pkg::smm_res_t                   res,
	input  wire logic                           cfg_we,
	input  wire logic [smm_pkg::CNT_CFG_W-1:0]  cfg_wdata
);

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                              state_q;
	logic [smm_pkg::CNT_CFG_W-1:0]       cnt_q;
	logic                                done_q;
	smm_pkg::smm_res_t                   res_q;
	logic [smm_pkg::ADDR_BITS-1:0]       addr_q;
	logic [smm_pkg::LIMIT_W-1:0]         limit_q;
	logic [smm_pkg::LIMIT_W-1:0]         issue_q;
	logic                                rd_vld_s1;
	logic                                rd_last_s1;

	logic [smm_pkg::LIMIT_W-1:0]         limit;
	logic                                accept;
	logic                                wr_en;
	logic [smm_pkg::TBL_AW-1:0]          wr_addr;
	logic [smm_pkg::WORD_W-1:0]          wr_word;
	logic                                issue;
	logic [smm_pkg::WORD_W-1:0]          rd_word;
	logic [smm_pkg::ADDR_BITS-1:0]       rd_net;
	logic [smm_pkg::ADDR_BITS-1:0]       rd_mask;
	logic                                match;
	logic                                finish;

	assign busy   = (state_q == ST_SCAN);
	assign accept = start && !busy;

	// Active entry count, saturated at the table depth
	always_comb begin
		if (32'(cnt_q) > smm_pkg::TABLE_DEPTH) begin
			limit = smm_pkg::LIMIT_W'(smm_pkg::TABLE_DEPTH);
		end else begin
			limit = smm_pkg::LIMIT_W'(cnt_q);
		end
	end

	// Load path: slots beyond the table are dropped
	assign wr_en   = accept && (req.req_type == smm_pkg::REQ_LOAD)
	                 && (32'(req.entry_index) < smm_pkg::TABLE_DEPTH);
	assign wr_addr = smm_pkg::TBL_AW'(req.entry_index);
	assign wr_word = {smm_pkg::prefix_mask(req.prefix_len), req.entry_net};

	// Scan: one read per cycle, compare on the registered data
	assign rd_mask = rd_word[smm_pkg::WORD_W-1:smm_pkg::ADDR_BITS];
	assign rd_net  = rd_word[smm_pkg::ADDR_BITS-1:0];
	assign match   = ((rd_mask & addr_q) == rd_net);
	assign finish  = rd_vld_s1 && (match || rd_last_s1);
	assign issue   = (state_q == ST_SCAN) && (issue_q < limit_q) && !finish;

	smm_ram #(
		.WIDTH(smm_pkg::WORD_W),
		.DEPTH(smm_pkg::TABLE_DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_word),
		.re   (issue),
		.raddr(issue_q[smm_pkg::TBL_AW-1:0]),
		.rdata(rd_word)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.req_type == smm_pkg::REQ_LOOKUP && limit != '0) begin
							state_q <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: scan pointer, address, result
	always_ff @(posedge clk) begin
		rd_last_s1 <= (issue_q + smm_pkg::LIMIT_W'(1) == limit_q);
		if (accept) begin
			issue_q         <= '0;
			limit_q         <= limit;
			addr_q          <= req.lookup_addr;
			res_q.is_lookup <= req.req_type;
			res_q.in_list   <= 1'b0;
		end else if (issue) begin
			issue_q <= issue_q + smm_pkg::LIMIT_W'(1);
		end
		if (finish) begin
			res_q.is_lookup <= 1'b1;
			res_q.in_list   <= match;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// Checks
	`SMM_ASSERT_NEVER(a_done_while_busy, clk, arst_n, done && busy, "result during scan")
	`SMM_ASSERT(a_load_ack, clk, arst_n, accept && (req.req_type == smm_pkg::REQ_LOAD) |=> done && !res.is_lookup, "load not acknowledged next cycle")
	`SMM_ASSERT(a_scan_end, clk, arst_n, $fell(busy) |-> done && res.is_lookup, "scan ended without lookup result")
	`SMM_ASSERT(a_rd_in_scan, clk, arst_n, rd_vld_s1 |-> (state_q == ST_SCAN), "table read outside scan")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 8;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	smm_pkg::smm_req_t             req = '0;
	logic                          done;
	smm_pkg::smm_res_t             res;
	logic                          cfg_we = 1'b0;
	logic [smm_pkg::CNT_CFG_W-1:0] cfg_wdata = '0;

	subnet_membership_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Items waiting for the driver and answers waiting for the monitor
	smm_pkg::smm_req_t pending_items[$];
	smm_pkg::smm_res_t expected_answers[$];

	// Predicted table contents and active entry count
	logic [31:0] tbl_net[smm_pkg::TABLE_DEPTH];
	logic [31:0] tbl_mask[smm_pkg::TABLE_DEPTH];
	int unsigned active_count = 0;

	// Stimulus-side view of the table, as it will stand once queued items run
	logic [31:0] plan_net[smm_pkg::TABLE_DEPTH];
	logic [31:0] plan_mask[smm_pkg::TABLE_DEPTH];
	bit          plan_loaded[smm_pkg::TABLE_DEPTH];
	int unsigned plan_count = 0;

	int error_count  = 0;
	int load_count   = 0;
	int lookup_count = 0;
	int hit_count    = 0;
	int setting_count = 0;
	int idle_cycles  = 0;

	// Driver burst state
	int burst_left = 0;
	int gap_left   = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	function automatic logic [31:0] mask_of_prefix(input logic [5:0] plen);
		if (plen == 6'd0)
			return 32'h0;
		if (plen >= 6'd32)
			return 32'hFFFF_FFFF;
		return ~((32'h1 << (6'd32 - plen)) - 32'h1);
	endfunction

	// Hit when some active entry's masked address equals its stored network
	function automatic logic table_hit(input logic [31:0] addr);
		int unsigned lim;
		lim = (active_count > smm_pkg::TABLE_DEPTH) ? smm_pkg::TABLE_DEPTH : active_count;
		for (int t = 0; t < lim; t++) begin
			if ((tbl_mask[t] & addr) == tbl_net[t])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Update the predicted table and queue the answer for one accepted item
	task automatic apply_item(input smm_pkg::smm_req_t it);
		smm_pkg::smm_res_t answer;
		if (it.req_type == smm_pkg::REQ_LOAD) begin
			tbl_net[it.entry_index]  = it.entry_net;
			tbl_mask[it.entry_index] = mask_of_prefix(it.prefix_len);
			answer.is_lookup = 1'b0;
			answer.in_list   = 1'b0;
			load_count++;
		end else begin
			answer.is_lookup = 1'b1;
			answer.in_list   = table_hit(it.lookup_addr);
			lookup_count++;
		end
		expected_answers.push_back(answer);
	endtask

	// Unused fields carry random junk
	task automatic queue_load(input int idx, input logic [31:0] net, input logic [5:0] plen);
		smm_pkg::smm_req_t it;
		it.req_type    = smm_pkg::REQ_LOAD;
		it.entry_index = 9'(idx);
		it.entry_net   = net;
		it.prefix_len  = plen;
		it.lookup_addr = $urandom;
		pending_items.push_back(it);
		plan_net[idx]    = net;
		plan_mask[idx]   = mask_of_prefix(plen);
		plan_loaded[idx] = 1'b1;
	endtask

	task automatic queue_lookup(input logic [31:0] addr);
		smm_pkg::smm_req_t it;
		it.req_type    = smm_pkg::REQ_LOOKUP;
		it.entry_index = 9'($urandom);
		it.entry_net   = $urandom;
		it.prefix_len  = 6'($urandom);
		it.lookup_addr = addr;
		pending_items.push_back(it);
	endtask

	// Random entry: mostly a clean network, sometimes with host bits left set
	task automatic queue_random_load(input int idx);
		logic [5:0]  plen;
		logic [31:0] net;
		if ($urandom_range(0, 99) < 80)
			plen = 6'($urandom_range(0, 32));
		else
			plen = 6'($urandom_range(33, 63));
		net = $urandom;
		// a clean prefix-zero entry would match everything and end every scan early
		if (plen != 6'd0 && $urandom_range(0, 99) < 75)
			net = net & mask_of_prefix(plen);
		queue_load(idx, net, plen);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || start || expected_answers.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Change the table size once the block is idle; fill any slot it would expose
	task automatic set_entry_count(input int unsigned value);
		int unsigned lim;
		lim = (value > smm_pkg::TABLE_DEPTH) ? smm_pkg::TABLE_DEPTH : value;
		for (int i = 0; i < lim; i++) begin
			if (!plan_loaded[i])
				queue_random_load(i);
		end
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= smm_pkg::CNT_CFG_W'(value);
		@(posedge clk);
		cfg_we       <= 1'b0;
		active_count = value;
		plan_count   = value;
		setting_count++;
	endtask

	task automatic run_random_phase(input int unsigned count);
		int unsigned lim;
		int k;
		logic [31:0] addr;
		set_entry_count(count);
		lim = (count > smm_pkg::TABLE_DEPTH) ? smm_pkg::TABLE_DEPTH : count;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 40) begin
				queue_random_load($urandom_range(0, smm_pkg::TABLE_DEPTH - 1));
			end else begin
				if (lim > 0 && $urandom_range(0, 99) < 60) begin
					// aim at an active entry with random host bits
					k = $urandom_range(0, lim - 1);
					addr = plan_net[k] | ($urandom & ~plan_mask[k]);
				end else if ($urandom_range(0, 99) < 10) begin
					addr = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
				end else begin
					addr = $urandom;
				end
				queue_lookup(addr);
			end
		end
	endtask

	// Driver: bursts of items with random gaps between them
	always @(posedge clk) begin
		logic              nxt_start;
		smm_pkg::smm_req_t nxt_req;
		if (!arst_n) begin
			start      <= 1'b0;
			req        <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			nxt_start = start;
			nxt_req   = req;
			if (start && !busy) begin
				apply_item(req);
				nxt_start = 1'b0;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0) begin
					nxt_req   = pending_items.pop_front();
					nxt_start = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			start <= nxt_start;
			req   <= nxt_req;
		end
	end

	// Monitor: every strobed result must match the oldest expectation
	always @(posedge clk) begin
		smm_pkg::smm_res_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result is_lookup=%0b in_list=%0b",
					res.is_lookup, res.in_list));
			end else begin
				want = expected_answers.pop_front();
				if (res.is_lookup !== want.is_lookup)
					report_mismatch($sformatf("is_lookup got %0b want %0b",
						res.is_lookup, want.is_lookup));
				if (res.in_list !== want.in_list)
					report_mismatch($sformatf("in_list got %0b want %0b (lookup %0d)",
						res.in_list, want.in_list, lookup_count));
				if (want.in_list)
					hit_count++;
			end
		end
	end

	// Cycles with no item accepted and no result seen
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned counts[7];
		counts = '{1, 33, 0, 512, 1023, 150, 5};
		@(posedge arst_n);
		@(posedge clk);

		// Empty table: nothing can match
		queue_lookup(32'h0000_0000);

		// Directed entries: full host, common prefixes, saturating length,
		// one-bit prefix, unmasked network, prefix zero and the top slot
		queue_load(0, 32'hFFFF_FFFF, 6'd32);
		queue_load(1, 32'hC0A8_0000, 6'd16);
		queue_load(2, 32'h0A00_0000, 6'd8);
		queue_load(3, 32'h1234_5678, 6'd40);
		queue_load(4, 32'h8000_0000, 6'd1);
		queue_load(5, 32'hDEAD_BEEE, 6'd31);
		queue_load(6, 32'h0A00_0001, 6'd8);
		queue_load(7, 32'h0000_0000, 6'd0);
		queue_load(smm_pkg::TABLE_DEPTH - 1, 32'h5A5A_A5A5, 6'd63);

		set_entry_count(7);
		queue_lookup(32'hFFFF_FFFF);
		queue_lookup(32'hC0A8_1234);
		queue_lookup(32'h0A00_00FF);
		queue_lookup(32'h1234_5678);
		queue_lookup(32'h1234_5679);
		queue_lookup(32'h8000_0001);
		queue_lookup(32'hDEAD_BEEF);
		queue_lookup(32'h0000_0000);
		queue_lookup(32'h0A00_0001);

		// Prefix zero entry now active: any address matches
		set_entry_count(8);
		queue_lookup(32'h5555_AAAA);

		foreach (counts[i])
			run_random_phase(counts[i]);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items: %0d loads, %0d lookups, %0d hits", load_count + lookup_count,
			load_count, lookup_count, hit_count);
		$display("Table size changed %0d times, from empty to beyond the table", setting_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/smm_pkg.sv
sv/smm_ram.sv
sv/subnet_membership_matcher.sv
test/testbench.sv
